// ----- hw/rtl/bfsp_pkg.sv -----
package bfsp_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_VERTICES = 32;
   localparam int DEF_WEIGHT_BITS  = 16;
   // Distance word: weight width, twice the vertex index width of headroom, plus one guard bit and a sign bit
   localparam int DEF_DIST_BITS    = DEF_WEIGHT_BITS + 2 * $clog2(DEF_MAX_VERTICES) + 2;

   // Weight value that means "no edge" (zero means the same)
   localparam int NO_EDGE_MARK = 10000;

   // Fixed field widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;
   localparam int VERTEX_W    = 6;
   localparam int STATUS_W    = 2;
   localparam int DIST_OUT_W  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET       = 2'd2;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] VCOUNT_RESET = 6'd32;
   localparam logic [CSR_DATA_W-1:0] SOURCE_RESET = 6'd1;
   localparam logic [CSR_DATA_W-1:0] TARGET_RESET = 6'd1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_UNREACHABLE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEG_CYCLE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PATH        = 2'd2;

   // Decision of the relax unit for one edge
   typedef struct packed {
      logic take_dist;   // relaxation phase: new best distance for v
      logic mark_neg;    // cycle phase: v is hit by a negative cycle
   } relax_dec_type;

endpackage

// ----- hw/rtl/bfsp_ram.sv -----
module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/bfsp_relax_unit.sv -----
module bfsp_relax_unit
   import bfsp_pkg::*;
#(
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
   parameter int DIST_BITS   = DEF_DIST_BITS
) (
   input  logic                          phase_neg,
   input  logic signed [DIST_BITS-1:0]   dist_u,
   input  logic signed [WEIGHT_BITS-1:0] weight,
   input  logic signed [DIST_BITS-1:0]   dist_v,
   input  logic                          reached_v,
   input  logic                          neg_u,
   output logic signed [DIST_BITS-1:0]   sum,
   output relax_dec_type                 dec
);

   logic signed [32:0] w_wide;
   logic               edge_ok;
   logic               better;

   always_comb begin
      w_wide  = 33'(weight);
      edge_ok = (w_wide != 33'sd0) && (w_wide != 33'(NO_EDGE_MARK));
      sum     = dist_u + DIST_BITS'(weight);
      better  = sum < dist_v;
      dec.take_dist = !phase_neg && edge_ok && (!reached_v || better);
      dec.mark_neg  = phase_neg && edge_ok && (neg_u || !reached_v || better);
   end

endmodule

// ----- hw/rtl/bellman_ford_shortest_path.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_weight (one matrix entry, row-major)
// rsp       out        rsp_valid/rsp_ready  rsp_status, rsp_distance, rsp_vertex, rsp_last
// csr       in         csr_wen              csr_index, csr_wdata (write only)
//
// A request that does not complete the matrix is written to the weight store.
// The request completing the N x N matrix starts the search: an init step, then
// 2N-1 rounds; each round fetches, scans and drains every reached row and skips
// each unreached row, with the single add/compare unit handling one edge per cycle.
// Path walk stores each path vertex and fetches its predecessor; output reads each
// one back and hands it to the output register. req_ready stays low from the last entry
// until the last result is loaded into the output register. Reset is synchronous; it
// clears control state and sets the config registers to their defaults. The stores
// need no clearing pass. A stalled rsp holds the sequencer in its output step.
module bellman_ford_shortest_path
   import bfsp_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [WEIGHT_BITS-1:0] req_weight,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DIST_OUT_W-1:0]  rsp_distance,
   output logic [VERTEX_W-1:0]           rsp_vertex,
   output logic                          rsp_last,
   // configuration
   input  logic                          csr_wen,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int VIDX_W     = $clog2(MAX_VERTICES);
   localparam int CNT_W      = $clog2(MAX_VERTICES + 1);
   localparam int EDGE_DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int EADDR_W    = $clog2(EDGE_DEPTH);
   localparam int SQ_W       = 2 * CNT_W;
   localparam int DIST_BITS  = WEIGHT_BITS + 2 * VIDX_W + 2;
   localparam int VW         = (CNT_W > VERTEX_W) ? CNT_W : VERTEX_W;
   localparam int CMP_W      = VW + 1;
   localparam int SAT_W      = (DIST_BITS > DIST_OUT_W) ? DIST_BITS : DIST_OUT_W;
   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32'sh7FFF_FFFF);
   localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(32'sh8000_0000);

   // sequencer states
   localparam logic [3:0] S_LOAD    = 4'd0;   // taking matrix entries
   localparam logic [3:0] S_INIT    = 4'd1;   // seed the source
   localparam logic [3:0] S_ROWRD   = 4'd2;   // fetch dist[u], or skip unreached row
   localparam logic [3:0] S_SCAN    = 4'd3;   // issue one edge u->v per cycle
   localparam logic [3:0] S_DRAIN   = 4'd4;   // finish last edge of row, advance
   localparam logic [3:0] S_RESULT  = 4'd5;   // classify target
   localparam logic [3:0] S_SEND1   = 4'd6;   // single status result
   localparam logic [3:0] S_DISTRD  = 4'd7;   // capture target distance
   localparam logic [3:0] S_WALK    = 4'd8;   // store path vertex, fetch predecessor
   localparam logic [3:0] S_WALKWT  = 4'd9;   // step to predecessor
   localparam logic [3:0] S_EMITRD  = 4'd10;  // read path buffer
   localparam logic [3:0] S_EMITOUT = 4'd11;  // hand path vertex to output register

   // config registers
   logic [CSR_DATA_W-1:0] vcount_ff, vcount_in;
   logic [CSR_DATA_W-1:0] src_ff, src_in;
   logic [CSR_DATA_W-1:0] tgt_ff, tgt_in;

   // control
   logic [3:0]            state_ff, state_in;
   logic [EADDR_W-1:0]    load_cnt_ff, load_cnt_in;
   logic                  phase_ff, phase_in;      // 0 relaxation, 1 negative-cycle marking
   logic                  first_ff, first_in;      // first scan cycle of a row
   logic                  b_valid_ff, b_valid_in;  // edge in the compare stage
   logic [MAX_VERTICES-1:0] reached_ff, reached_in;
   logic [MAX_VERTICES-1:0] neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [VIDX_W-1:0]     u_ff, u_in;
   logic [VIDX_W-1:0]     v_ff, v_in;
   logic [VIDX_W-1:0]     b_v_ff, b_v_in;
   logic [EADDR_W-1:0]    base_ff, base_in;        // u * n
   logic [CNT_W-1:0]      round_ff, round_in;      // rounds left in this phase
   logic signed [DIST_BITS-1:0] du_ff, du_in;      // current dist[u]
   logic [VIDX_W-1:0]     cur_ff, cur_in;
   logic [CNT_W-1:0]      len_ff, len_in;
   logic [VIDX_W-1:0]     idx_ff, idx_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic signed [DIST_OUT_W-1:0] dist_out_ff, dist_out_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic signed [DIST_OUT_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic [VERTEX_W-1:0]   rsp_vertex_ff, rsp_vertex_in;
   logic                  rsp_last_ff, rsp_last_in;

   // derived config
   logic [CNT_W-1:0]      n_act;
   logic [VIDX_W-1:0]     n_last_idx;
   logic [SQ_W-1:0]       n_sq;
   logic [SQ_W-1:0]       loaded_next;
   logic                  src_ok, tgt_ok;
   logic [VIDX_W-1:0]     src_idx, tgt_idx;

   // memories
   logic                          req_fire;
   logic signed [WEIGHT_BITS-1:0] edge_rdata;
   logic                          dist_we;
   logic [VIDX_W-1:0]             dist_waddr, dist_raddr;
   logic signed [DIST_BITS-1:0]   dist_wdata, dist_rdata;
   logic                          pred_we;
   logic [VIDX_W-1:0]             pred_rdata;
   logic                          pbuf_we;
   logic [VIDX_W-1:0]             pbuf_rdata;

   // relax unit
   logic signed [DIST_BITS-1:0] relax_sum;
   relax_dec_type               relax_dec;

   // misc
   logic                  out_free;
   logic                  row_adv;
   logic [VW-1:0]         vplus;
   logic signed [SAT_W-1:0] dwide;

   // ------------------------------------------------------------------
   // Config decode and active vertex count
   // ------------------------------------------------------------------
   always_comb begin
      vcount_in = vcount_ff;
      src_in    = src_ff;
      tgt_in    = tgt_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: vcount_in = csr_wdata;
            CSR_SOURCE:       src_in    = csr_wdata;
            CSR_TARGET:       tgt_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      // zero counts as one, large counts saturate
      if (vcount_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (CMP_W'(vcount_ff) > CMP_W'(MAX_VERTICES)) begin
         n_act = CNT_W'(MAX_VERTICES);
      end else begin
         n_act = CNT_W'(vcount_ff);
      end
      n_last_idx  = VIDX_W'(n_act - CNT_W'(1));
      n_sq        = SQ_W'(n_act) * SQ_W'(n_act);
      loaded_next = SQ_W'(load_cnt_ff) + SQ_W'(1);
      src_ok      = (src_ff != '0) && (CMP_W'(src_ff) <= CMP_W'(n_act));
      src_idx     = VIDX_W'(src_ff - CSR_DATA_W'(1));
      tgt_idx     = VIDX_W'(tgt_ff - CSR_DATA_W'(1));
      tgt_ok      = (tgt_ff != '0) && (CMP_W'(tgt_ff) <= CMP_W'(n_act)) &&
                    reached_ff[tgt_idx];
   end

   assign req_ready = (state_ff == S_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ------------------------------------------------------------------
   // Shared add/compare unit: one edge per cycle
   // ------------------------------------------------------------------
   bfsp_relax_unit #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .DIST_BITS   (DIST_BITS)
   ) u_relax (
      .phase_neg (phase_ff),
      .dist_u    (du_ff),
      .weight    (edge_rdata),
      .dist_v    (dist_rdata),
      .reached_v (reached_ff[b_v_ff]),
      .neg_u     (neg_ff[u_ff]),
      .sum       (relax_sum),
      .dec       (relax_dec)
   );

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      load_cnt_in     = load_cnt_ff;
      phase_in        = phase_ff;
      first_in        = first_ff;
      b_valid_in      = 1'b0;
      reached_in      = reached_ff;
      neg_in          = neg_ff;
      u_in            = u_ff;
      v_in            = v_ff;
      b_v_in          = b_v_ff;
      base_in         = base_ff;
      round_in        = round_ff;
      du_in           = du_ff;
      cur_in          = cur_ff;
      len_in          = len_ff;
      idx_in          = idx_ff;
      res_status_in   = res_status_ff;
      dist_out_in     = dist_out_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_distance_in = rsp_distance_ff;
      rsp_vertex_in   = rsp_vertex_ff;
      rsp_last_in     = rsp_last_ff;
      dist_we         = 1'b0;
      dist_waddr      = b_v_ff;
      dist_wdata      = relax_sum;
      dist_raddr      = v_ff;
      pred_we         = 1'b0;
      pbuf_we         = 1'b0;
      row_adv         = 1'b0;
      vplus           = VW'(pbuf_rdata) + VW'(1);
      dwide           = SAT_W'(dist_rdata);

      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (loaded_next >= n_sq) begin
                  load_cnt_in = '0;
                  state_in    = S_INIT;
               end else begin
                  load_cnt_in = EADDR_W'(loaded_next);
               end
            end
         end
         S_INIT: begin
            reached_in = '0;
            neg_in     = '0;
            if (src_ok) begin
               reached_in[src_idx] = 1'b1;
               dist_we    = 1'b1;
               dist_waddr = src_idx;
               dist_wdata = '0;
            end
            u_in    = '0;
            base_in = '0;
            if (n_act == CNT_W'(1)) begin
               // no relaxation rounds, go straight to marking
               phase_in = 1'b1;
               round_in = n_act;
            end else begin
               phase_in = 1'b0;
               round_in = n_act - CNT_W'(1);
            end
            state_in = S_ROWRD;
         end
         S_ROWRD: begin
            if (reached_ff[u_ff]) begin
               dist_raddr = u_ff;
               v_in       = '0;
               first_in   = 1'b1;
               state_in   = S_SCAN;
            end else begin
               row_adv = 1'b1;
            end
         end
         S_SCAN: begin
            dist_raddr = v_ff;
            b_valid_in = 1'b1;
            b_v_in     = v_ff;
            if (first_ff) begin
               du_in    = dist_rdata;
               first_in = 1'b0;
            end
            if (v_ff == n_last_idx) begin
               state_in = S_DRAIN;
            end else begin
               v_in = v_ff + VIDX_W'(1);
            end
         end
         S_DRAIN: begin
            row_adv = 1'b1;
         end
         S_RESULT: begin
            if (!tgt_ok) begin
               res_status_in = ST_UNREACHABLE;
               state_in      = S_SEND1;
            end else if (neg_ff[tgt_idx]) begin
               res_status_in = ST_NEG_CYCLE;
               state_in      = S_SEND1;
            end else begin
               dist_raddr = tgt_idx;
               state_in   = S_DISTRD;
            end
         end
         S_SEND1: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_distance_in = '0;
               rsp_vertex_in   = '0;
               rsp_last_in     = 1'b1;
               state_in        = S_LOAD;
            end
         end
         S_DISTRD: begin
            // clamp to the 32-bit result range
            if (dwide > SAT_HI) begin
               dist_out_in = DIST_OUT_W'(SAT_HI);
            end else if (dwide < SAT_LO) begin
               dist_out_in = DIST_OUT_W'(SAT_LO);
            end else begin
               dist_out_in = DIST_OUT_W'(dwide);
            end
            cur_in   = tgt_idx;
            len_in   = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            // path stored target first; predecessor of cur is read meanwhile
            pbuf_we = 1'b1;
            len_in  = len_ff + CNT_W'(1);
            if ((cur_ff == src_idx) || (len_ff + CNT_W'(1) >= n_act)) begin
               idx_in   = len_ff[VIDX_W-1:0];
               state_in = S_EMITRD;
            end else begin
               state_in = S_WALKWT;
            end
         end
         S_WALKWT: begin
            cur_in   = pred_rdata;
            state_in = S_WALK;
         end
         S_EMITRD: begin
            state_in = S_EMITOUT;
         end
         S_EMITOUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_PATH;
               rsp_distance_in = dist_out_ff;
               rsp_vertex_in   = vplus[VERTEX_W-1:0];
               rsp_last_in     = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff - VIDX_W'(1);
                  state_in = S_EMITRD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // next row / next round / next phase
      if (row_adv) begin
         if (u_ff == n_last_idx) begin
            u_in    = '0;
            base_in = '0;
            if (round_ff == CNT_W'(1)) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  round_in = n_act;
                  state_in = S_ROWRD;
               end else begin
                  state_in = S_RESULT;
               end
            end else begin
               round_in = round_ff - CNT_W'(1);
               state_in = S_ROWRD;
            end
         end else begin
            u_in     = u_ff + VIDX_W'(1);
            base_in  = base_ff + EADDR_W'(n_act);
            state_in = S_ROWRD;
         end
      end

      // compare stage: commit the unit's decision for edge u->b_v
      if (b_valid_ff && relax_dec.take_dist) begin
         dist_we             = 1'b1;
         dist_waddr          = b_v_ff;
         dist_wdata          = relax_sum;
         reached_in[b_v_ff]  = 1'b1;
         pred_we             = 1'b1;
         if (b_v_ff == u_ff) begin
            // self loop lowered dist[u]; later edges of the row see it
            du_in = relax_sum;
         end
      end
      if (b_valid_ff && relax_dec.mark_neg) begin
         neg_in[b_v_ff] = 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_cnt_ff  <= '0;
         phase_ff     <= 1'b0;
         first_ff     <= 1'b0;
         b_valid_ff   <= 1'b0;
         reached_ff   <= '0;
         neg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= VCOUNT_RESET;
         src_ff       <= SOURCE_RESET;
         tgt_ff       <= TARGET_RESET;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         b_valid_ff   <= b_valid_in;
         reached_ff   <= reached_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
         vcount_ff    <= vcount_in;
         src_ff       <= src_in;
         tgt_ff       <= tgt_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff            <= u_in;
      v_ff            <= v_in;
      b_v_ff          <= b_v_in;
      base_ff         <= base_in;
      round_ff        <= round_in;
      du_ff           <= du_in;
      cur_ff          <= cur_in;
      len_ff          <= len_in;
      idx_ff          <= idx_in;
      res_status_ff   <= res_status_in;
      dist_out_ff     <= dist_out_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_vertex_ff   <= rsp_vertex_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_vertex   = rsp_vertex_ff;
   assign rsp_last     = rsp_last_ff;

   // ------------------------------------------------------------------
   // Stores
   // ------------------------------------------------------------------
   // weight matrix, row-major, written by requests, read at u*n+v
   bfsp_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (EDGE_DEPTH)
   ) u_edge_ram (
      .clock (clock),
      .we    (req_fire),
      .waddr (load_cnt_ff),
      .wdata (req_weight),
      .raddr (base_ff + EADDR_W'(v_ff)),
      .rdata (edge_rdata)
   );

   // best distance per vertex
   bfsp_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_dist_ram (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (dist_wdata),
      .raddr (dist_raddr),
      .rdata (dist_rdata)
   );

   // predecessor per vertex
   bfsp_ram #(
      .WIDTH (VIDX_W),
      .DEPTH (MAX_VERTICES)
   ) u_pred_ram (
      .clock (clock),
      .we    (pred_we),
      .waddr (b_v_ff),
      .wdata (u_ff),
      .raddr (cur_ff),
      .rdata (pred_rdata)
   );

   // path, target first; read back in reverse
   bfsp_ram #(
      .WIDTH (VIDX_W),
      .DEPTH (MAX_VERTICES)
   ) u_path_ram (
      .clock (clock),
      .we    (pbuf_we),
      .waddr (len_ff[VIDX_W-1:0]),
      .wdata (cur_ff),
      .raddr (idx_ff),
      .rdata (pbuf_rdata)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // compare stage only follows an issue cycle
   a_bvalid_from_scan: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> $past(state_ff == S_SCAN))
      else $error("compare stage active without issue");

   // reached bits only rise between search starts
   a_reached_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INIT) |=> ((reached_ff & $past(reached_ff)) == $past(reached_ff)))
      else $error("reached bit cleared mid-search");

   // relaxation phase never marks negative cycles
   a_no_neg_in_relax: assert property (@(posedge clock) disable iff (reset)
      (!phase_ff && (state_ff != S_INIT)) |=> $stable(neg_ff))
      else $error("negative-cycle mark during relaxation");

   // a new result only comes from an output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_SEND1 || state_ff == S_EMITOUT))
      else $error("result loaded outside output step");

   // path never longer than the vertex count
   a_path_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (len_ff < n_act))
      else $error("path walk overran vertex count");

endmodule

// ----- tb/route_checker.sv -----
`timescale 1ns / 1ps

module route_checker
   import bfsp_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [DEF_WEIGHT_BITS-1:0] req_weight,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [STATUS_W-1:0]               rsp_status,
   input  logic signed [DIST_OUT_W-1:0]      rsp_distance,
   input  logic [VERTEX_W-1:0]               rsp_vertex,
   input  logic                              rsp_last,
   input  logic                              csr_wen,
   input  logic [CSR_INDEX_W-1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0]             csr_wdata,
   output int                                mismatches,
   output int                                hops_pending
);

   localparam int MAXV = DEF_MAX_VERTICES;
   localparam longint DIST_MAX = 64'sd2147483647;
   localparam longint DIST_MIN = -64'sd2147483648;

   typedef struct {
      logic [STATUS_W-1:0]          status;
      logic signed [DIST_OUT_W-1:0] distance;
      logic [VERTEX_W-1:0]          vertex;
      logic                         last_hop;
   } route_hop_type;

   route_hop_type         route_hops[$];
   longint                edge_store[MAXV*MAXV];
   logic [CSR_DATA_W-1:0] count_reg;
   logic [CSR_DATA_W-1:0] source_reg;
   logic [CSR_DATA_W-1:0] target_reg;
   int unsigned           loaded;

   initial mismatches = 0;

   function automatic int vertices_in_use();
      if (count_reg == 0) return 1;
      if (count_reg > MAXV) return MAXV;
      return int'(count_reg);
   endfunction

   function automatic bit is_edge(input longint w);
      return w != 0 && w != NO_EDGE_MARK;
   endfunction

   task automatic push_hop(input logic [STATUS_W-1:0] status, input longint distance,
                           input int vertex, input bit last_hop);
      route_hop_type hop;
      hop.status   = status;
      hop.distance = distance[DIST_OUT_W-1:0];
      hop.vertex   = vertex[VERTEX_W-1:0];
      hop.last_hop = last_hop;
      route_hops.insert(route_hops.size(), hop);
   endtask

   // relaxation rounds, then cycle marking, then the path walk back from the target
   task automatic solve_route();
      int     n;
      int     src;
      int     tgt;
      int     rnd;
      int     u;
      int     v;
      int     hops;
      int     cur;
      int     k;
      longint w;
      longint d;
      longint best[MAXV];
      bit     reach[MAXV];
      bit     neg[MAXV];
      int     pred[MAXV];
      int     trail[MAXV];
      bit     walking;
      n   = vertices_in_use();
      src = int'(source_reg);
      tgt = int'(target_reg);
      for (k = 0; k < MAXV; k++) begin
         best[k]  = 0;
         reach[k] = 1'b0;
         neg[k]   = 1'b0;
         pred[k]  = 0;
      end
      if (src >= 1 && src <= n) reach[src-1] = 1'b1;
      for (rnd = 1; rnd < n; rnd++) begin
         for (u = 0; u < n; u++) begin
            for (v = 0; v < n; v++) begin
               w = edge_store[u*n+v];
               if (reach[u] && is_edge(w) && (!reach[v] || best[u] + w < best[v])) begin
                  best[v]  = best[u] + w;
                  reach[v] = 1'b1;
                  pred[v]  = u;
               end
            end
         end
      end
      // anything still improvable, or fed by a marked vertex, sits on a negative cycle
      for (rnd = 0; rnd < n; rnd++) begin
         for (u = 0; u < n; u++) begin
            for (v = 0; v < n; v++) begin
               w = edge_store[u*n+v];
               if (reach[u] && is_edge(w) &&
                   (neg[u] || !reach[v] || best[u] + w < best[v]))
                  neg[v] = 1'b1;
            end
         end
      end
      if (tgt < 1 || tgt > n || !reach[tgt-1]) begin
         push_hop(ST_UNREACHABLE, 0, 0, 1'b1);
      end else if (neg[tgt-1]) begin
         push_hop(ST_NEG_CYCLE, 0, 0, 1'b1);
      end else begin
         d = best[tgt-1];
         if (d > DIST_MAX) d = DIST_MAX;
         if (d < DIST_MIN) d = DIST_MIN;
         hops    = 0;
         cur     = tgt - 1;
         walking = 1'b1;
         while (walking) begin
            trail[hops] = cur;
            hops++;
            if (cur == src - 1 || hops >= n) walking = 1'b0;
            else cur = pred[cur] % MAXV;
         end
         for (k = hops - 1; k >= 0; k--) push_hop(ST_PATH, d, trail[k] + 1, k == 0);
      end
   endtask

   task automatic check_field(input string label, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      route_hop_type hop;
      int            n;
      if (reset) begin
         route_hops.delete();
         count_reg  = VCOUNT_RESET;
         source_reg = SOURCE_RESET;
         target_reg = TARGET_RESET;
         loaded     = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_VERTEX_COUNT: count_reg = csr_wdata;
               CSR_SOURCE:       source_reg = csr_wdata;
               CSR_TARGET:       target_reg = csr_wdata;
               default:          ;
            endcase
         end
         if (req_valid && req_ready) begin
            n = vertices_in_use();
            if (loaded < MAXV * MAXV) edge_store[loaded] = longint'(req_weight);
            loaded++;
            if (loaded >= n * n) begin
               loaded = 0;
               solve_route();
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (route_hops.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected, status %0d distance %0d vertex %0d",
                        $time, rsp_status, rsp_distance, rsp_vertex);
            end else begin
               hop = route_hops.pop_front();
               check_field("status", hop.status, rsp_status);
               check_field("distance", hop.distance, rsp_distance);
               check_field("vertex", hop.vertex, rsp_vertex);
               check_field("last", hop.last_hop, rsp_last);
            end
         end
      end
      hops_pending <= route_hops.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import bfsp_pkg::*;

   // unused register index: a write there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   // cycles the block may need after its last result before it is back to idle
   localparam int unsigned SETTLE_CYCLES = 16;
   // watchdog limit on the whole run
   localparam int unsigned LIMIT_CYCLES = 1000000;
   // vertices of the chain graph
   localparam int unsigned CHAIN_N = 16;
   // directed part + one 16-vertex chain + random small-matrix requests
   localparam int unsigned ITEM_TARGET = 460;
   localparam int unsigned QUIET_FROM = ITEM_TARGET - 60;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [DEF_WEIGHT_BITS-1:0] req_weight = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [STATUS_W-1:0]               rsp_status;
   logic signed [DIST_OUT_W-1:0]      rsp_distance;
   logic [VERTEX_W-1:0]               rsp_vertex;
   logic                              rsp_last;
   logic                              csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0]             csr_wdata = '0;

   int          mismatches;
   int          hops_pending;
   bit          quiet = 1'b0;      // set for the tail of the run: no idling on either side
   int unsigned items_sent = 0;
   int unsigned stall_left = 0;

   bellman_ford_shortest_path dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_weight   (req_weight),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_distance (rsp_distance),
      .rsp_vertex   (rsp_vertex),
      .rsp_last     (rsp_last),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   route_checker route_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_weight   (req_weight),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_distance (rsp_distance),
      .rsp_vertex   (rsp_vertex),
      .rsp_last     (rsp_last),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .hops_pending (hops_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: random stall bursts, none once the run goes quiet.
   always @(posedge clock) begin
      if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 4);
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Small graphs: a mix of no-edge marks, short positive edges, a few negative
   // edges (so some graphs carry negative cycles), long edges and raw 16-bit noise.
   // The chain graph is u -> u+1 with cheap edges plus rare costly extras, so the
   // path from the first to the last vertex runs through every vertex.
   function automatic logic signed [DEF_WEIGHT_BITS-1:0] pick_weight(input bit chained,
                                                                  input bit on_chain);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (chained) begin
         if (on_chain) return 16'($urandom_range(1, 100));
         if (r < 3) return 16'($urandom_range(3200, 32767));
         return r[0] ? 16'(NO_EDGE_MARK) : 16'd0;
      end
      if (r < 35) return r[0] ? 16'(NO_EDGE_MARK) : 16'd0;
      if (r < 80) return 16'($urandom_range(1, 300));
      if (r < 92) return 16'(-int'($urandom_range(1, 40)));
      if (r < 97) return 16'($urandom_range(301, 32767));
      return 16'($urandom());
   endfunction

   // Mostly a vertex in range; now and then zero or a value past the count.
   function automatic logic [CSR_DATA_W-1:0] pick_vertex(input int unsigned n);
      int unsigned r;
      r = $urandom_range(0, 11);
      if (r == 0) return '0;
      if (r == 1) return CSR_DATA_W'($urandom_range(n + 1, 63));
      return CSR_DATA_W'($urandom_range(1, n));
   endfunction

   // One request: valid goes up with the weight and stays until accepted.
   // An optional idle burst follows; otherwise valid stays high for the next request.
   task automatic send_weight(input logic signed [DEF_WEIGHT_BITS-1:0] w);
      req_valid  <= 1'b1;
      req_weight <= w;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_block(input int unsigned count);
      repeat (count) send_weight(pick_weight(1'b0, 1'b0));
   endtask

   // Stop sending, wait for every outstanding result, then let the block go idle.
   // Register writes follow this, apart from those right after reset.
   task automatic hold_sender();
      req_valid <= 1'b0;
      do @(posedge clock); while (hops_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Wen is a one-cycle strobe so back-to-back writes never double-drive it.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned n;
      int unsigned n2;
      int unsigned k;
      int unsigned r;
      int unsigned cur_n;
      int unsigned u;
      int unsigned v;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      write_reg(CSR_UNUSED, 6'h3F);

      // single vertex, no edge: path of just the source, distance zero
      write_reg(CSR_VERTEX_COUNT, 6'd1);
      write_reg(CSR_SOURCE, 6'd1);
      write_reg(CSR_TARGET, 6'd1);
      send_weight(16'sd0);
      hold_sender();

      // count zero acts as one; most negative self-loop -> negative cycle
      write_reg(CSR_VERTEX_COUNT, 6'd0);
      send_weight(16'sh8000);
      hold_sender();

      // two vertices, largest weight on 1->2, no-edge mark on 2->1
      write_reg(CSR_VERTEX_COUNT, 6'd2);
      write_reg(CSR_TARGET, 6'd2);
      send_weight(16'sd0);
      send_weight(16'sd32767);
      send_weight(16'(NO_EDGE_MARK));
      send_weight(16'sd0);
      hold_sender();

      // only 2->1 exists: target unreachable
      send_weight(16'sd0);
      send_weight(16'(NO_EDGE_MARK));
      send_weight(16'sd5);
      send_weight(16'sd0);
      hold_sender();

      // source out of range: nothing reached
      write_reg(CSR_SOURCE, 6'd0);
      send_weight(16'sd0);
      send_weight(16'sd7);
      send_weight(16'sd7);
      send_weight(16'sd0);
      hold_sender();

      // target out of range
      write_reg(CSR_SOURCE, 6'd1);
      write_reg(CSR_TARGET, 6'd3);
      send_weight(16'sd0);
      send_weight(16'sd7);
      send_weight(16'sd7);
      send_weight(16'sd0);
      hold_sender();

      // count drops from 3 to 2 after four entries: the fifth request starts the
      // search on the first four, which form the cycle 1->2->1 of weight -2
      write_reg(CSR_VERTEX_COUNT, 6'd3);
      write_reg(CSR_TARGET, 6'd2);
      send_weight(16'sd0);
      send_weight(-16'sd3);
      send_weight(16'sd1);
      send_weight(16'sd0);
      hold_sender();
      write_reg(CSR_VERTEX_COUNT, 6'd2);
      send_weight(16'sd20);
      hold_sender();

      // count written above the maximum saturates to 32: five entries start nothing;
      // then the count drops to 3 and the ninth entry starts the search
      write_reg(CSR_VERTEX_COUNT, 6'd63);
      write_reg(CSR_SOURCE, 6'd1);
      write_reg(CSR_TARGET, 6'd3);
      send_block(5);
      hold_sender();
      write_reg(CSR_VERTEX_COUNT, 6'd3);
      send_block(4);
      hold_sender();

      // ---- chain graph: the path runs through every vertex ----
      write_reg(CSR_VERTEX_COUNT, CSR_DATA_W'(CHAIN_N));
      write_reg(CSR_SOURCE, 6'd1);
      write_reg(CSR_TARGET, CSR_DATA_W'(CHAIN_N));
      for (u = 0; u < CHAIN_N; u++)
         for (v = 0; v < CHAIN_N; v++)
            send_weight(pick_weight(1'b1, v == u + 1));

      // ---- random small graphs ----
      cur_n = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= QUIET_FROM) quiet = 1'b1;
         if (cur_n != 0 && $urandom_range(0, 3) == 0) begin
            // same setting again, queued right behind the search still in flight
            send_block(cur_n * cur_n);
         end else begin
            r = $urandom_range(0, 19);
            n = (r == 0) ? 1 : (r < 17) ? $urandom_range(2, 6) : $urandom_range(7, 9);
            hold_sender();
            write_reg(CSR_VERTEX_COUNT,
                      (n == 1 && $urandom_range(0, 1) == 1) ? 6'd0 : CSR_DATA_W'(n));
            write_reg(CSR_SOURCE, pick_vertex(n));
            write_reg(CSR_TARGET, pick_vertex(n));
            if (n > 1 && $urandom_range(0, 7) == 0) begin
               // count changed partway through loading; entries keep their places
               n2 = $urandom_range(1, 6);
               k  = $urandom_range(1, n * n - 1);
               send_block(k);
               hold_sender();
               write_reg(CSR_VERTEX_COUNT, CSR_DATA_W'(n2));
               send_block((n2 * n2 > k) ? n2 * n2 - k : 1);
               n = n2;
            end else begin
               send_block(n * n);
            end
            cur_n = n;
         end
      end

      hold_sender();
      if (mismatches == 0 && hops_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

endmodule
